/* design/aes_ecb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ecb_pkg
// Shared types, constants and byte functions for the AES ECB block.
// ----------------------------------------------------------------------------
package aes_ecb_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int NUM_ROWS   = MAX_ROUNDS + 1;
  localparam int ROW_W      = $clog2(NUM_ROWS);

  localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
  localparam logic [2:0] REG_KEY_WORD3 = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INIT,
    CELL_STEP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     dec;
    logic     last;
  } cell_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [1:0]       col;
    logic [31:0]      word;
  } rk_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kx_stat_t;

  typedef enum logic {
    KX_IDLE,
    KX_RUN
  } kx_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_INIT,
    CS_ROUND
  } core_state_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] inv_sub_word(input logic [31:0] w);
    return {INV_BOX[w[31:24]], INV_BOX[w[23:16]], INV_BOX[w[15:8]], INV_BOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

  // multiples 9, b, d, e of one byte
  function automatic logic [31:0] mul_9bde(input logic [7:0] a);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
    return {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [31:0] m0, m1, m2, m3;
    // each mN = {9a, ba, da, ea}
    m0 = mul_9bde(w[31:24]); m1 = mul_9bde(w[23:16]);
    m2 = mul_9bde(w[15:8]);  m3 = mul_9bde(w[7:0]);
    return {m0[7:0]   ^ m1[23:16] ^ m2[15:8]  ^ m3[31:24],
            m0[31:24] ^ m1[7:0]   ^ m2[23:16] ^ m3[15:8],
            m0[15:8]  ^ m1[31:24] ^ m2[7:0]   ^ m3[23:16],
            m0[23:16] ^ m1[15:8]  ^ m2[31:24] ^ m3[7:0]};
  endfunction

  // key length in words; unused code acts as 256, sizes beyond MAX_ROUNDS step down
  function automatic logic [3:0] key_nk(input logic [1:0] ks);
    logic [1:0] sel;
    sel = (ks == 2'd3) ? KS_256 : ks;
    for (int k = 0; k < 2; k++) begin
      if (sel != KS_128 && (10 + 2 * int'(sel)) > MAX_ROUNDS) begin
        sel = sel - 2'd1;
      end
    end
    return 4'd4 + {1'b0, sel, 1'b0};
  endfunction

endpackage

/* design/aes_ecb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ecb_if
// Valid/ready channels: data blocks in, results out, register writes.
// ----------------------------------------------------------------------------
interface aes_ecb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, mode, block_high, block_low, input ready);
  modport sink   (input valid, mode, block_high, block_low, output ready);
endinterface

interface aes_ecb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_ecb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/aes_ecb_keyexp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ecb_keyexp
// Key schedule sequencer: one round-key word per cycle into the cell banks.
// ----------------------------------------------------------------------------
module aes_ecb_keyexp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          abort,
  input  logic [3:0]                    nk,
  input  logic [3:0][63:0]              key_words,
  output aes_ecb_pkg::rk_wr_t           wr,
  output aes_ecb_pkg::kx_stat_t         stat
);
  import aes_ecb_pkg::*;

  kx_state_t       state, state_next;
  logic [5:0]      cnt;
  logic [2:0]      jm;
  logic [7:0]      rc;
  logic [3:0]      nk_q;
  logic [7:0][31:0] win;

  logic [5:0]  last_idx;
  logic [63:0] kw_pair;
  logic [31:0] key_word;
  logic [31:0] prev, back, sw_in, sw_out, t, word;
  logic        from_key, jm_wrap;

  assign last_idx = {nk_q + 4'd6, 2'b11};
  assign from_key = cnt < {2'b00, nk_q};
  assign kw_pair  = key_words[cnt[2:1]];
  assign key_word = cnt[0] ? kw_pair[31:0] : kw_pair[63:32];
  assign prev     = win[0];
  assign jm_wrap  = ({1'b0, jm} == nk_q - 4'd1);

  always_comb begin
    case (nk_q)
      4'd4:    back = win[3];
      4'd6:    back = win[5];
      default: back = win[7];
    endcase
  end

  assign sw_in  = (jm == 3'd0) ? {prev[23:0], prev[31:24]} : prev;
  assign sw_out = sub_word(sw_in);

  always_comb begin
    if (jm == 3'd0) begin
      t = sw_out ^ {rc, 24'h0};
    end else if (nk_q == 4'd8 && jm == 3'd4) begin
      t = sw_out;
    end else begin
      t = prev;
    end
    word = from_key ? key_word : (back ^ t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.busy  = (state == KX_RUN);
    stat.done  = 1'b0;
    case (state)
      KX_IDLE: begin
        if (start && !abort) begin
          state_next = KX_RUN;
        end
      end
      KX_RUN: begin
        if (abort) begin
          state_next = KX_IDLE;
        end else if (cnt == last_idx) begin
          state_next = KX_IDLE;
          stat.done  = 1'b1;
        end
      end
      default: state_next = KX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == KX_IDLE) begin
      cnt  <= '0;
      jm   <= '0;
      rc   <= 8'h01;
      nk_q <= nk;
    end else begin
      cnt <= cnt + 6'd1;
      jm  <= jm_wrap ? 3'd0 : jm + 3'd1;
      win <= {win[6:0], word};
      if (!from_key && jm == 3'd0) begin
        rc <= xtime(rc);
      end
    end
  end

  assign wr.en   = (state == KX_RUN) && !abort;
  assign wr.row  = cnt[5:2];
  assign wr.col  = cnt[1:0];
  assign wr.word = word;

endmodule

/* design/aes_ecb_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ecb_cell
// One state column: its round-key bank and one full round per cycle when stepped.
// ----------------------------------------------------------------------------
module aes_ecb_cell (
  input  logic                           clk,
  input  logic [1:0]                     col_id,
  input  aes_ecb_pkg::cell_ctrl_t        ctrl,
  input  logic [31:0]                    load_col,
  input  logic [31:0]                    shift_col,
  input  logic [aes_ecb_pkg::ROW_W-1:0]  rd_row,
  input  aes_ecb_pkg::rk_wr_t            wr,
  output logic [31:0]                    col_q,
  output logic [31:0]                    col_next
);
  import aes_ecb_pkg::*;

  logic [31:0] mem [NUM_ROWS];
  logic [31:0] rk;
  logic [31:0] enc_sb, dec_x;

  always_ff @(posedge clk) begin
    if (wr.en && wr.col == col_id) begin
      mem[wr.row] <= wr.word;
    end
    rk <= mem[rd_row];
  end

  assign enc_sb = sub_word(shift_col);
  assign dec_x  = inv_sub_word(shift_col) ^ rk;

  always_comb begin
    case (ctrl.op)
      CELL_LOAD: col_next = load_col;
      CELL_INIT: col_next = col_q ^ rk;
      CELL_STEP: begin
        if (ctrl.dec) begin
          col_next = ctrl.last ? dec_x : inv_mix_col(dec_x);
        end else begin
          col_next = (ctrl.last ? enc_sb : mix_col(enc_sb)) ^ rk;
        end
      end
      default: col_next = col_q;
    endcase
  end

  always_ff @(posedge clk) begin
    col_q <= col_next;
  end

endmodule

/* design/aes_block_cipher_ecb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_top
// AES-128/192/256 ECB: four column cells, one round per cycle unless the output is full.
// ----------------------------------------------------------------------------
// Steps: load, whitening, Nr rounds into the output register (Nr = 10, 12 or 14).
// Flow: the cell row runs one round per cycle and holds a single block, so no
//   new item is taken before the last is through. Next item is taken while a result waits.
// Key expansion: one word per cycle, 4*(Nr+1) words; it reruns after reset or
//   any key register write, and no item is accepted until the keys are ready.
// Reset: synchronous, active high; key_size = 256, key words zero.
module aes_block_cipher_ecb_top (
  input  logic clk,
  input  logic rst,
  aes_ecb_in_if.sink    blk,
  aes_ecb_out_if.source res,
  aes_ecb_cfg_if.sink   cfg
);
  import aes_ecb_pkg::*;

  // configuration registers
  logic [1:0]       key_size;
  logic [3:0][63:0] key_words;
  logic             keys_ready;
  logic             cfg_hit;
  logic [3:0]       nr_q;

  // key schedule
  rk_wr_t   kx_wr;
  kx_stat_t kx_stat;
  logic     kx_start;

  // cipher core
  core_state_t      state, state_next;
  logic [ROW_W-1:0] rnd, rnd_next;
  logic             dec;
  logic             last_rnd;
  cell_ctrl_t       ctrl;
  logic             blk_acc;
  logic             out_load;

  // cell row
  logic [3:0][31:0] col_q, col_next, load_col, shift_col;

  assign cfg.ready = 1'b1;
  // writes past the register list are dropped and leave the keys alone
  assign cfg_hit = cfg.valid && (cfg.index inside {REG_KEY_SIZE, REG_KEY_WORD0, REG_KEY_WORD1,
                                                   REG_KEY_WORD2, REG_KEY_WORD3});

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size  <= KS_256;
      key_words <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_SIZE:  key_size     <= cfg.data[1:0];
        REG_KEY_WORD0: key_words[0] <= cfg.data;
        REG_KEY_WORD1: key_words[1] <= cfg.data;
        REG_KEY_WORD2: key_words[2] <= cfg.data;
        REG_KEY_WORD3: key_words[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // a key write restarts the schedule from scratch
  assign kx_start = !keys_ready && !kx_stat.busy && !cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
    end else if (cfg_hit) begin
      keys_ready <= 1'b0;
    end else if (kx_stat.done) begin
      keys_ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kx_start) begin
      nr_q <= key_nk(key_size) + 4'd6;
    end
  end

  aes_ecb_keyexp u_keyexp (
    .clk       (clk),
    .rst       (rst),
    .start     (kx_start),
    .abort     (cfg_hit),
    .nk        (key_nk(key_size)),
    .key_words (key_words),
    .wr        (kx_wr),
    .stat      (kx_stat)
  );

  // block in stream order: column c is bytes 4c..4c+3
  assign load_col = {blk.block_high, blk.block_low};

  assign blk.ready = (state == CS_IDLE) && keys_ready;
  assign blk_acc   = blk.valid && blk.ready;

  // last round: forward ends at Nr, inverse ends at round key 0
  assign last_rnd = dec ? (rnd == '0) : (rnd == nr_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rnd <= rnd_next;
    if (blk_acc) begin
      dec <= blk.mode;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    ctrl.op    = CELL_HOLD;
    ctrl.dec   = dec;
    ctrl.last  = last_rnd;
    out_load   = 1'b0;
    case (state)
      CS_IDLE: begin
        if (blk_acc) begin
          state_next = CS_INIT;
          ctrl.op    = CELL_LOAD;
          rnd_next   = blk.mode ? nr_q : '0;
        end
      end
      CS_INIT: begin
        // whitening with the first round key
        ctrl.op    = CELL_INIT;
        state_next = CS_ROUND;
        rnd_next   = dec ? rnd - 4'd1 : rnd + 4'd1;
      end
      CS_ROUND: begin
        if (!last_rnd) begin
          ctrl.op  = CELL_STEP;
          rnd_next = dec ? rnd - 4'd1 : rnd + 4'd1;
        end else if (!res.valid || res.ready) begin
          // final round goes straight into the output register
          ctrl.op    = CELL_STEP;
          out_load   = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // four column cells; ShiftRows (or its inverse) is the byte crossover between the cells
  for (genvar c = 0; c < 4; c++) begin : g_cell
    for (genvar r = 0; r < 4; r++) begin : g_byte
      assign shift_col[3-c][31-8*r -: 8] =
        dec ? col_q[3-((c - r + 4) % 4)][31-8*r -: 8]
            : col_q[3-((c + r) % 4)][31-8*r -: 8];
    end

    aes_ecb_cell u_cell (
      .clk       (clk),
      .col_id    (2'(c)),
      .ctrl      (ctrl),
      .load_col  (load_col[3-c]),
      .shift_col (shift_col[3-c]),
      .rd_row    (rnd_next),
      .wr        (kx_wr),
      .col_q     (col_q[3-c]),
      .col_next  (col_next[3-c])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.result_high <= {col_next[3], col_next[2]};
      res.result_low  <= {col_next[1], col_next[0]};
    end
  end

endmodule
